// ----- sv/qsr_pkg.sv -----
// types, pattern codes and binomial helper for the quintet split ranker
`default_nettype none

package qsr_pkg;

    localparam int LBL_W = 7;
    localparam int IDX_W = 27;
    localparam int PAT_W = 4;
    localparam int TBL_N = 2 ** LBL_W;

    // interleaving pattern codes
    localparam logic [PAT_W-1:0] PAT_LEFT_LOW   = 4'd0;
    localparam logic [PAT_W-1:0] PAT_RL_LRL     = 4'd1;
    localparam logic [PAT_W-1:0] PAT_RL_LLR     = 4'd2;
    localparam logic [PAT_W-1:0] PAT_LR_RRL     = 4'd3;
    localparam logic [PAT_W-1:0] PAT_LR_RLR     = 4'd4;
    localparam logic [PAT_W-1:0] PAT_LR_LRR     = 4'd5;
    localparam logic [PAT_W-1:0] PAT_LT_RRL     = 4'd6;
    localparam logic [PAT_W-1:0] PAT_LT_RLR     = 4'd7;
    localparam logic [PAT_W-1:0] PAT_LT_LRR     = 4'd8;
    localparam logic [PAT_W-1:0] PAT_LEFT_HIGH  = 4'd9;

    typedef struct packed {
        logic [LBL_W-1:0] left_a;
        logic [LBL_W-1:0] left_b;
        logic [LBL_W-1:0] right_a;
        logic [LBL_W-1:0] right_b;
        logic [LBL_W-1:0] right_c;
    } split_t;

    typedef struct packed {
        logic [IDX_W-1:0] split_index;
        logic [LBL_W-1:0] left_hi;
        logic [LBL_W-1:0] left_lo;
        logic [LBL_W-1:0] right_hi;
        logic [LBL_W-1:0] right_mid;
        logic [LBL_W-1:0] right_lo;
    } result_t;

    // C(label-1, k) through pascal rows, zero for labels outside 1..max_taxon
    function automatic longint binom(int label, int k, int max_taxon);
        longint row [0:5];
        int n;
        int j;
        for (j = 0; j <= 5; j++)
        begin
            row[j] = 0;
        end
        row[0] = 1;
        if (label < 1 || label > max_taxon || k < 0 || k > 5)
        begin
            return 0;
        end
        for (n = 1; n < label; n++)
        begin
            for (j = 5; j >= 1; j--)
            begin
                row[j] = row[j] + row[j-1];
            end
        end
        return row[k];
    endfunction

endpackage

`default_nettype wire

// ----- sv/quintet_split_rank.sv -----
// quintet split ranker: sorts both blocks, finds the pattern, ranks the split
// the accepted split is held in the input register; done and the result come from the result register
// throughput: one item per cycle, busy is always low
// path: input register, sort and five constant table lookups, result register
// reset clears the valid bits of both stages, payload registers are not reset
// the receiver cannot stall: each result shows for exactly one cycle
`default_nettype none

module quintet_split_rank
    import qsr_pkg::*;
#(
    parameter int MAX_TAXON = 64
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire split_t  split,
    output logic         done,
    output result_t      rank
);

    logic [IDX_W-1:0] tab1 [TBL_N];
    logic [IDX_W-1:0] tab2 [TBL_N];
    logic [IDX_W-1:0] tab3 [TBL_N];
    logic [IDX_W-1:0] tab4 [TBL_N];
    logic [IDX_W-1:0] tab5 [TBL_N];

    for (genvar g = 0; g < TBL_N; g++)
    begin : g_tab
        assign tab1[g] = IDX_W'(binom(g, 1, MAX_TAXON));
        assign tab2[g] = IDX_W'(binom(g, 2, MAX_TAXON));
        assign tab3[g] = IDX_W'(binom(g, 3, MAX_TAXON));
        assign tab4[g] = IDX_W'(binom(g, 4, MAX_TAXON));
        assign tab5[g] = IDX_W'(binom(g, 5, MAX_TAXON));
    end

    logic    in_vld_reg;
    split_t  in_reg;
    logic    out_vld_reg;
    logic    out_vld_next;
    result_t out_reg;
    result_t out_next;

    logic [LBL_W-1:0] l0, l1, r0, r1, r2;
    logic [LBL_W-1:0] ra0, ra1, rb1, rb2;
    logic [LBL_W-1:0] v5, v4, v3, v2, v1;
    logic [PAT_W-1:0] pat;
    logic [IDX_W-1:0] rk;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start && !busy;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= split;
        end
        if (out_vld_next)
        begin
            out_reg <= out_next;
        end
    end

    // descending sorts: one swap on the left, three-stage network on the right
    always_comb
    begin
        l0 = (in_reg.left_a < in_reg.left_b) ? in_reg.left_b : in_reg.left_a;
        l1 = (in_reg.left_a < in_reg.left_b) ? in_reg.left_a : in_reg.left_b;
        ra0 = (in_reg.right_a < in_reg.right_b) ? in_reg.right_b : in_reg.right_a;
        ra1 = (in_reg.right_a < in_reg.right_b) ? in_reg.right_a : in_reg.right_b;
        rb1 = (ra1 < in_reg.right_c) ? in_reg.right_c : ra1;
        rb2 = (ra1 < in_reg.right_c) ? ra1 : in_reg.right_c;
        r0 = (ra0 < rb1) ? rb1 : ra0;
        r1 = (ra0 < rb1) ? ra0 : rb1;
        r2 = rb2;
    end

    // pattern detection picks the five labels in descending order
    always_comb
    begin
        if (l0 < r2)
        begin
            {v5, v4, v3, v2, v1} = {r0, r1, r2, l0, l1};
            pat = PAT_LEFT_LOW;
        end
        else if (l1 > r0)
        begin
            {v5, v4, v3, v2, v1} = {l0, l1, r0, r1, r2};
            pat = PAT_LEFT_HIGH;
        end
        else if (l0 < r1)
        begin
            if (l1 < r2)
            begin
                {v5, v4, v3, v2, v1} = {r0, r1, l0, r2, l1};
                pat = PAT_RL_LRL;
            end
            else
            begin
                {v5, v4, v3, v2, v1} = {r0, r1, l0, l1, r2};
                pat = PAT_RL_LLR;
            end
        end
        else if (l0 < r0)
        begin
            if (l1 < r2)
            begin
                {v5, v4, v3, v2, v1} = {r0, l0, r1, r2, l1};
                pat = PAT_LR_RRL;
            end
            else if (l1 < r1)
            begin
                {v5, v4, v3, v2, v1} = {r0, l0, r1, l1, r2};
                pat = PAT_LR_RLR;
            end
            else
            begin
                {v5, v4, v3, v2, v1} = {r0, l0, l1, r1, r2};
                pat = PAT_LR_LRR;
            end
        end
        else
        begin
            if (l1 < r2)
            begin
                {v5, v4, v3, v2, v1} = {l0, r0, r1, r2, l1};
                pat = PAT_LT_RRL;
            end
            else if (l1 < r1)
            begin
                {v5, v4, v3, v2, v1} = {l0, r0, r1, l1, r2};
                pat = PAT_LT_RLR;
            end
            else
            begin
                {v5, v4, v3, v2, v1} = {l0, r0, l1, r1, r2};
                pat = PAT_LT_LRR;
            end
        end
    end

    // rank wraps modulo 2^27; times ten as two shifted adds
    always_comb
    begin
        rk = tab5[v5] + tab4[v4] + tab3[v3] + tab2[v2] + tab1[v1];
        out_next.split_index = (rk << 3) + (rk << 1) + IDX_W'(pat);
        out_next.left_hi     = l0;
        out_next.left_lo     = l1;
        out_next.right_hi    = r0;
        out_next.right_mid   = r1;
        out_next.right_lo    = r2;
        out_vld_next         = in_vld_reg;
    end

    assign done = out_vld_reg;
    assign rank = out_reg;

endmodule

`default_nettype wire
